>>> rtl/core/dsdr_pkg.sv
// shared types, register codes and the digit segment tables of the digit renderer
package dsdr_pkg;

  // sizes fixed by the field widths
  localparam int unsigned ValueW = 15;
  localparam int unsigned CoordW = 8;
  localparam int unsigned DigitW = 4;
  localparam int unsigned SegIdxW = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned MaxDigitsDefault = 5;

  // reciprocal of ten, exact for every 15-bit value
  localparam int unsigned RecipShift = 19;
  localparam logic [15:0] RecipTen = 16'd52429;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DIGIT_PITCH = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DIGIT_WIDTH = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DIGIT_HEIGHT = 3'd4;

  // register reset values
  localparam logic [CoordW-1:0] RST_ORIGIN_X = 8'd30;
  localparam logic [CoordW-1:0] RST_ORIGIN_Y = 8'd22;
  localparam logic [CoordW-1:0] RST_DIGIT_PITCH = 8'd15;
  localparam logic [CoordW-1:0] RST_DIGIT_WIDTH = 8'd10;
  localparam logic [CoordW-1:0] RST_DIGIT_HEIGHT = 8'd20;

  // offset and length selectors
  typedef enum logic [1:0] {
    SEL_ZERO  = 2'd0,
    SEL_WIDTH = 2'd1,
    SEL_HALF  = 2'd2,
    SEL_FULL  = 2'd3
  } sel_e;

  typedef struct packed {
    sel_e xs;
    sel_e ys;
    sel_e ls;
    logic vert;
  } seg_t;

  // horizontal segment at an offset, full width long
  function automatic seg_t hseg(sel_e xs, sel_e ys);
    seg_t r;
    r.xs = xs;
    r.ys = ys;
    r.ls = SEL_WIDTH;
    r.vert = 1'b0;
    return r;
  endfunction

  function automatic seg_t vseg(sel_e xs, sel_e ys, sel_e ls);
    seg_t r;
    r.xs = xs;
    r.ys = ys;
    r.ls = ls;
    r.vert = 1'b1;
    return r;
  endfunction

  // number of segments of each digit
  function automatic logic [SegIdxW-1:0] seg_count(logic [DigitW-1:0] d);
    logic [SegIdxW-1:0] c;
    case (d)
      4'd0: c = 3'd4;
      4'd1: c = 3'd1;
      4'd2: c = 3'd5;
      4'd3: c = 3'd4;
      4'd4: c = 3'd3;
      4'd5: c = 3'd5;
      4'd6: c = 3'd5;
      4'd7: c = 3'd2;
      4'd8: c = 3'd5;
      4'd9: c = 3'd5;
      default: c = 3'd1;
    endcase
    return c;
  endfunction

  // segment s of digit d, in drawing order
  function automatic seg_t seg_lookup(logic [DigitW-1:0] d, logic [SegIdxW-1:0] s);
    seg_t r;
    r = hseg(SEL_ZERO, SEL_ZERO);
    case (d)
      4'd0: begin
        case (s)
          3'd1: r = hseg(SEL_ZERO, SEL_FULL);
          3'd2: r = vseg(SEL_ZERO, SEL_ZERO, SEL_FULL);
          3'd3: r = vseg(SEL_WIDTH, SEL_ZERO, SEL_FULL);
          default: r = hseg(SEL_ZERO, SEL_ZERO);
        endcase
      end
      4'd1: r = vseg(SEL_WIDTH, SEL_ZERO, SEL_FULL);
      4'd2: begin
        case (s)
          3'd1: r = vseg(SEL_WIDTH, SEL_ZERO, SEL_HALF);
          3'd2: r = hseg(SEL_ZERO, SEL_HALF);
          3'd3: r = vseg(SEL_ZERO, SEL_HALF, SEL_HALF);
          3'd4: r = hseg(SEL_ZERO, SEL_FULL);
          default: r = hseg(SEL_ZERO, SEL_ZERO);
        endcase
      end
      4'd3: begin
        case (s)
          3'd1: r = hseg(SEL_ZERO, SEL_HALF);
          3'd2: r = hseg(SEL_ZERO, SEL_FULL);
          3'd3: r = vseg(SEL_WIDTH, SEL_ZERO, SEL_FULL);
          default: r = hseg(SEL_ZERO, SEL_ZERO);
        endcase
      end
      4'd4: begin
        case (s)
          3'd1: r = hseg(SEL_ZERO, SEL_HALF);
          3'd2: r = vseg(SEL_WIDTH, SEL_ZERO, SEL_FULL);
          default: r = vseg(SEL_ZERO, SEL_ZERO, SEL_HALF);
        endcase
      end
      4'd5: begin
        case (s)
          3'd1: r = vseg(SEL_ZERO, SEL_ZERO, SEL_HALF);
          3'd2: r = hseg(SEL_ZERO, SEL_HALF);
          3'd3: r = vseg(SEL_WIDTH, SEL_HALF, SEL_HALF);
          3'd4: r = hseg(SEL_ZERO, SEL_FULL);
          default: r = hseg(SEL_ZERO, SEL_ZERO);
        endcase
      end
      4'd6: begin
        case (s)
          3'd1: r = hseg(SEL_ZERO, SEL_HALF);
          3'd2: r = hseg(SEL_ZERO, SEL_FULL);
          3'd3: r = vseg(SEL_WIDTH, SEL_HALF, SEL_HALF);
          3'd4: r = vseg(SEL_ZERO, SEL_ZERO, SEL_FULL);
          default: r = hseg(SEL_ZERO, SEL_ZERO);
        endcase
      end
      4'd7: begin
        case (s)
          3'd1: r = vseg(SEL_WIDTH, SEL_ZERO, SEL_FULL);
          default: r = hseg(SEL_ZERO, SEL_ZERO);
        endcase
      end
      4'd8: begin
        case (s)
          3'd1: r = hseg(SEL_ZERO, SEL_HALF);
          3'd2: r = hseg(SEL_ZERO, SEL_FULL);
          3'd3: r = vseg(SEL_ZERO, SEL_ZERO, SEL_FULL);
          3'd4: r = vseg(SEL_WIDTH, SEL_ZERO, SEL_FULL);
          default: r = hseg(SEL_ZERO, SEL_ZERO);
        endcase
      end
      4'd9: begin
        case (s)
          3'd1: r = hseg(SEL_ZERO, SEL_HALF);
          3'd2: r = hseg(SEL_ZERO, SEL_FULL);
          3'd3: r = vseg(SEL_ZERO, SEL_ZERO, SEL_HALF);
          3'd4: r = vseg(SEL_WIDTH, SEL_ZERO, SEL_FULL);
          default: r = hseg(SEL_ZERO, SEL_ZERO);
        endcase
      end
      default: r = hseg(SEL_ZERO, SEL_ZERO);
    endcase
    return r;
  endfunction

  // selector to offset or length
  function automatic logic [CoordW-1:0] pick(sel_e sel, logic [CoordW-1:0] w,
                                             logic [CoordW-1:0] h);
    logic [CoordW-1:0] r;
    case (sel)
      SEL_WIDTH: r = w;
      SEL_HALF:  r = h >> 1;
      SEL_FULL:  r = h;
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/decimal_segment_digit_renderer_core.sv
// top level of the digit renderer: digit split by ten, then one segment per cycle
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, value_i            | input
//  out     | out_valid_o, out_ready_i, seg_x_o, seg_y_o, | output
//          | seg_length_o, vertical_o, last_o           |
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i,     | input
//          | cfg_data_i                                 |
//
// An item whose value has d decimal digits (none for zero) and S segments goes
// through these steps: it is accepted in idle, takes one divide per digit in the
// shared multiply-by-reciprocal divide-by-ten unit and one step to leave it, then
// yields one segment per cycle out of the output register while the output is not stalled.
// The input is not ready until the last segment is loaded into that register.
// Reset restores the register defaults and returns the sequencer to idle.
// An output stall holds the segment sequencer; configuration is always ready.
module decimal_segment_digit_renderer_core #(
  parameter int unsigned MAX_DIGITS = dsdr_pkg::MaxDigitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dsdr_pkg::ValueW-1:0]   value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dsdr_pkg::CoordW-1:0]   seg_x_o,
  output logic [dsdr_pkg::CoordW-1:0]   seg_y_o,
  output logic [dsdr_pkg::CoordW-1:0]   seg_length_o,
  output logic                          vertical_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dsdr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dsdr_pkg::CoordW-1:0]   cfg_data_i
);
  import dsdr_pkg::*;

  localparam int unsigned IdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned CntW = $clog2(MAX_DIGITS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_DIGITS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CoordW-1:0] origin_x_q, origin_y_q, digit_pitch_q, digit_width_q, digit_height_q;

  logic [ValueW-1:0] num_q, num_d;
  logic [CntW-1:0]   n_q, n_d;
  logic [CntW-1:0]   nz_q, nz_d;
  logic [DigitW-1:0] digs_q [MAX_DIGITS];
  logic [IdxW-1:0]   p_q, p_d;
  logic [SegIdxW-1:0] s_q, s_d;
  logic              zero_q, zero_d;
  logic [CoordW-1:0] bx_q, bx_d;

  logic              out_valid_q, out_valid_d;
  logic [CoordW-1:0] seg_x_q, seg_y_q, seg_length_q;
  logic              vertical_q, last_q;

  // shared divide-by-ten unit
  logic [ValueW+15:0] prod;
  logic [ValueW-1:0]  quot;
  logic [ValueW-1:0]  rem_full;
  logic [DigitW-1:0]  rem;
  logic               div_done;
  logic               dig_wr;

  assign prod     = num_q * RecipTen;
  assign quot     = ValueW'(prod >> RecipShift);
  assign rem_full = num_q - (quot << 3) - (quot << 1);
  assign rem      = rem_full[DigitW-1:0];
  assign div_done = (num_q == '0) || (n_q == MaxCnt);
  assign dig_wr   = (state_q == ST_DIV) && !div_done;

  // current digit and segment
  logic [DigitW-1:0]  cur_dig;
  logic [SegIdxW-1:0] cur_cnt;
  seg_t               cur_seg;
  logic               seg_last_of_dig;
  logic               seg_last;
  logic               load_out;

  assign cur_dig         = zero_q ? '0 : digs_q[p_q];
  assign cur_cnt         = seg_count(cur_dig);
  assign cur_seg         = seg_lookup(cur_dig, s_q);
  assign seg_last_of_dig = (s_q == cur_cnt - 3'd1);
  assign seg_last        = seg_last_of_dig && (p_q == '0);
  assign load_out        = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // sequencer
  always_comb begin
    state_d     = state_q;
    num_d       = num_q;
    n_d         = n_q;
    nz_d        = nz_q;
    p_d         = p_q;
    s_d         = s_q;
    zero_d      = zero_q;
    bx_d        = bx_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          num_d   = value_i;
          n_d     = '0;
          nz_d    = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          zero_d  = (nz_q == '0);
          p_d     = (nz_q == '0) ? '0 : IdxW'(nz_q - 1'b1);
          s_d     = '0;
          bx_d    = origin_x_q + digit_pitch_q;
          state_d = ST_EMIT;
        end else begin
          num_d = quot;
          n_d   = n_q + 1'b1;
          if (rem != '0) begin
            nz_d = n_q + 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          if (seg_last) begin
            state_d = ST_IDLE;
          end else if (seg_last_of_dig) begin
            s_d  = '0;
            p_d  = p_q - 1'b1;
            bx_d = bx_q + digit_pitch_q;
          end else begin
            s_d = s_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      nz_q        <= '0;
      p_q         <= '0;
      s_q         <= '0;
      zero_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
      nz_q        <= nz_d;
      p_q         <= p_d;
      s_q         <= s_d;
      zero_q      <= zero_d;
    end
  end

  // datapath registers and digit store
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    bx_q  <= bx_d;
    if (dig_wr) begin
      digs_q[n_q[IdxW-1:0]] <= rem;
    end
    if (load_out) begin
      seg_x_q      <= bx_q + pick(cur_seg.xs, digit_width_q, digit_height_q);
      seg_y_q      <= origin_y_q + pick(cur_seg.ys, digit_width_q, digit_height_q);
      seg_length_q <= pick(cur_seg.ls, digit_width_q, digit_height_q);
      vertical_q   <= cur_seg.vert;
      last_q       <= seg_last;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q     <= RST_ORIGIN_X;
      origin_y_q     <= RST_ORIGIN_Y;
      digit_pitch_q  <= RST_DIGIT_PITCH;
      digit_width_q  <= RST_DIGIT_WIDTH;
      digit_height_q <= RST_DIGIT_HEIGHT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ORIGIN_X:     origin_x_q     <= cfg_data_i;
        CFG_ORIGIN_Y:     origin_y_q     <= cfg_data_i;
        CFG_DIGIT_PITCH:  digit_pitch_q  <= cfg_data_i;
        CFG_DIGIT_WIDTH:  digit_width_q  <= cfg_data_i;
        CFG_DIGIT_HEIGHT: digit_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign seg_x_o      = seg_x_q;
  assign seg_y_o      = seg_y_q;
  assign seg_length_o = seg_length_q;
  assign vertical_o   = vertical_q;
  assign last_o       = last_q;

  // checks
  a_accept_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DIV))
    else $error("accepted transaction did not start the divide");

  a_nz_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nz_q <= n_q) && (n_q <= MaxCnt))
    else $error("digit counters out of range");

  a_emit_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (zero_q || (CntW'(p_q) < nz_q)))
    else $error("digit index beyond drawn digits");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && seg_last) |=> (state_q == ST_IDLE) && out_valid_o && last_o)
    else $error("last segment did not end the transaction");

endmodule

>>> tb/sv/tb_decimal_segment_digit_renderer_core.sv
// self-checking testbench of the decimal segment digit renderer core
`timescale 1ns / 100ps

module tb_decimal_segment_digit_renderer_core;
  import dsdr_pkg::*;

  localparam int unsigned MaxDigits = 5;
  localparam int unsigned LongStall = 300;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned TailCycles = 60;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned RandPhases = 7;
  localparam int unsigned PhaseItems = 50;
  localparam int unsigned PrintCap = 40;

  // one stroke of a glyph: direction, column and row offset, length
  typedef struct packed {
    logic vert;
    sel_e xs;
    sel_e ys;
    sel_e ls;
  } stroke_t;

  localparam stroke_t StrokeTop = {1'b0, SEL_ZERO, SEL_ZERO, SEL_WIDTH};
  localparam stroke_t StrokeMid = {1'b0, SEL_ZERO, SEL_HALF, SEL_WIDTH};
  localparam stroke_t StrokeBot = {1'b0, SEL_ZERO, SEL_FULL, SEL_WIDTH};
  localparam stroke_t StrokeLeftFull = {1'b1, SEL_ZERO, SEL_ZERO, SEL_FULL};
  localparam stroke_t StrokeRightFull = {1'b1, SEL_WIDTH, SEL_ZERO, SEL_FULL};
  localparam stroke_t StrokeLeftUpper = {1'b1, SEL_ZERO, SEL_ZERO, SEL_HALF};
  localparam stroke_t StrokeRightUpper = {1'b1, SEL_WIDTH, SEL_ZERO, SEL_HALF};
  localparam stroke_t StrokeLeftLower = {1'b1, SEL_ZERO, SEL_HALF, SEL_HALF};
  localparam stroke_t StrokeRightLower = {1'b1, SEL_WIDTH, SEL_HALF, SEL_HALF};

  // one drawn segment as it leaves the block
  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] len;
    logic       vert;
    logic       last;
  } seg_rec_t;

  // one full register setting
  typedef struct packed {
    logic [7:0] ox;
    logic [7:0] oy;
    logic [7:0] pitch;
    logic [7:0] width;
    logic [7:0] height;
  } cfg_set_t;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_TYPED,
    ROW_SETUP,
    ROW_SETUP_STRAY
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [14:0] value;
    cfg_set_t    setting;
    seg_rec_t    want;
  } row_t;

  localparam cfg_set_t SetReset = '{ox: 8'd30, oy: 8'd22, pitch: 8'd15, width: 8'd10,
                                    height: 8'd20};
  localparam cfg_set_t SetZeros = '{ox: 8'd0, oy: 8'd0, pitch: 8'd0, width: 8'd0,
                                    height: 8'd0};
  localparam cfg_set_t SetOnes = '{ox: 8'hFF, oy: 8'hFF, pitch: 8'hFF, width: 8'hFF,
                                   height: 8'hFF};
  localparam cfg_set_t SetOdd = '{ox: 8'd200, oy: 8'd250, pitch: 8'd60, width: 8'd77,
                                  height: 8'd255};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [14:0] value;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  seg_x;
  logic [7:0]  seg_y;
  logic [7:0]  seg_len;
  logic        seg_vert;
  logic        seg_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;

  // predictor state: register copies and the glyph table
  logic [7:0]  cfg_ox;
  logic [7:0]  cfg_oy;
  logic [7:0]  cfg_pitch;
  logic [7:0]  cfg_width;
  logic [7:0]  cfg_height;
  stroke_t     glyph_tab [0:9][0:4];
  int unsigned glyph_len [0:9];

  seg_rec_t    seg_expect [$];
  row_t        directed_rows [$];
  seg_rec_t    typed_want;
  bit          typed_armed;
  bit          src_live;
  bit          src_idle_en;
  bit          sink_idle_en;
  bit          long_stall_req;
  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned numbers_taken;
  int unsigned segs_seen;
  int unsigned cfg_writes;
  int unsigned settings_loaded;

  decimal_segment_digit_renderer_core #(
    .MAX_DIGITS(MaxDigits)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .seg_x_o     (seg_x),
    .seg_y_o     (seg_y),
    .seg_length_o(seg_len),
    .vertical_o  (seg_vert),
    .last_o      (seg_last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d segments still due", cycle_count,
               seg_expect.size());
      $display("tb_decimal_segment_digit_renderer_core: done, errors");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    err_count++;
    if (err_count <= PrintCap) $display("mismatch @%0d: %s", cycle_count, msg);
  endtask

  task automatic set_glyph(input int d, input int unsigned n, input stroke_t s0,
                           input stroke_t s1, input stroke_t s2, input stroke_t s3,
                           input stroke_t s4);
    glyph_len[d] = n;
    glyph_tab[d][0] = s0;
    glyph_tab[d][1] = s1;
    glyph_tab[d][2] = s2;
    glyph_tab[d][3] = s3;
    glyph_tab[d][4] = s4;
  endtask

  // strokes of each digit in drawing order; unused slots are padding
  task automatic load_glyphs();
    set_glyph(0, 4, StrokeTop, StrokeBot, StrokeLeftFull, StrokeRightFull, StrokeTop);
    set_glyph(1, 1, StrokeRightFull, StrokeTop, StrokeTop, StrokeTop, StrokeTop);
    set_glyph(2, 5, StrokeTop, StrokeRightUpper, StrokeMid, StrokeLeftLower, StrokeBot);
    set_glyph(3, 4, StrokeTop, StrokeMid, StrokeBot, StrokeRightFull, StrokeTop);
    set_glyph(4, 3, StrokeLeftUpper, StrokeMid, StrokeRightFull, StrokeTop, StrokeTop);
    set_glyph(5, 5, StrokeTop, StrokeLeftUpper, StrokeMid, StrokeRightLower, StrokeBot);
    set_glyph(6, 5, StrokeTop, StrokeMid, StrokeBot, StrokeRightLower, StrokeLeftFull);
    set_glyph(7, 2, StrokeTop, StrokeRightFull, StrokeTop, StrokeTop, StrokeTop);
    set_glyph(8, 5, StrokeTop, StrokeMid, StrokeBot, StrokeLeftFull, StrokeRightFull);
    set_glyph(9, 5, StrokeTop, StrokeMid, StrokeBot, StrokeLeftUpper, StrokeRightFull);
  endtask

  function automatic logic [7:0] stroke_span(input sel_e sel);
    case (sel)
      SEL_WIDTH: return cfg_width;
      SEL_HALF:  return cfg_height >> 1;
      SEL_FULL:  return cfg_height;
      default:   return 8'd0;
    endcase
  endfunction

  // expected segments of one number under the current register copies
  function automatic void render_number(input logic [14:0] num_in);
    int unsigned num;
    int unsigned n;
    int unsigned k;
    int unsigned s;
    logic [3:0]  digs [0:MaxDigits-1];
    logic [3:0]  d;
    logic [7:0]  base_x;
    stroke_t     st;
    seg_rec_t    r;
    num = num_in;
    n = 0;
    while (num != 0 && n < MaxDigits) begin
      digs[n] = 4'(num % 10);
      num = num / 10;
      n++;
    end
    // leading zeros are not drawn, an empty remainder draws one zero
    while (n > 0 && digs[n-1] == 4'd0) n--;
    if (n == 0) begin
      digs[0] = 4'd0;
      n = 1;
    end
    for (k = 1; k <= n; k++) begin
      d = digs[n-k];
      base_x = cfg_ox + cfg_pitch * 8'(k);
      for (s = 0; s < glyph_len[d]; s++) begin
        st = glyph_tab[d][s];
        r.x = base_x + stroke_span(st.xs);
        r.y = cfg_oy + stroke_span(st.ys);
        r.len = stroke_span(st.ls);
        r.vert = st.vert;
        r.last = (k == n) && (s == glyph_len[d] - 1);
        seg_expect.push_back(r);
      end
    end
  endfunction

  // input transaction monitor: queue the segments each number causes
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      numbers_taken++;
      if (typed_armed) begin
        seg_expect.push_back(typed_want);
        typed_armed = 1'b0;
      end else begin
        render_number(value);
      end
    end
  end

  // output transaction checker
  always @(posedge clk) begin : seg_check
    seg_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      segs_seen++;
      if (seg_expect.size() == 0) begin
        flag_mismatch($sformatf("segment x=%0d y=%0d len=%0d with none due", seg_x, seg_y,
                                seg_len));
      end else begin
        want = seg_expect.pop_front();
        if (seg_x !== want.x)
          flag_mismatch($sformatf("seg_x got %0d want %0d", seg_x, want.x));
        if (seg_y !== want.y)
          flag_mismatch($sformatf("seg_y got %0d want %0d", seg_y, want.y));
        if (seg_len !== want.len)
          flag_mismatch($sformatf("seg_length got %0d want %0d", seg_len, want.len));
        if (seg_vert !== want.vert)
          flag_mismatch($sformatf("vertical got %b want %b", seg_vert, want.vert));
        if (seg_last !== want.last)
          flag_mismatch($sformatf("last got %b want %b", seg_last, want.last));
      end
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin : sink_proc
    int unsigned burst;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_stall_req) begin
        out_ready <= 1'b0;
        repeat (LongStall - 1) @(negedge clk);
        long_stall_req = 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 5);
        out_ready <= 1'b0;
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // sender side: called at a falling edge, returns at a falling edge
  task automatic offer_value(input logic [14:0] v);
    in_valid <= 1'b1;
    value <= v;
    src_live = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drop_valid();
    if (src_live) begin
      in_valid <= 1'b0;
      src_live = 1'b0;
    end
  endtask

  task automatic source_gap();
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      drop_valid();
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    drop_valid();
    while (seg_expect.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // one register write transaction; valid stays up for a following write
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ORIGIN_X:     cfg_ox = data;
      CFG_ORIGIN_Y:     cfg_oy = data;
      CFG_DIGIT_PITCH:  cfg_pitch = data;
      CFG_DIGIT_WIDTH:  cfg_width = data;
      CFG_DIGIT_HEIGHT: cfg_height = data;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
  endtask

  // new setting once idle; stray writes go to indexes past the last register
  task automatic load_setting(input cfg_set_t s, input bit stray);
    wait_drained();
    write_reg(CFG_ORIGIN_X, s.ox);
    write_reg(CFG_ORIGIN_Y, s.oy);
    write_reg(CFG_DIGIT_PITCH, s.pitch);
    write_reg(CFG_DIGIT_WIDTH, s.width);
    write_reg(CFG_DIGIT_HEIGHT, s.height);
    if (stray) begin
      for (int i = 1; i <= 3; i++) write_reg(CFG_DIGIT_HEIGHT + 3'(i), 8'($urandom));
    end
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  function automatic row_t mk_row(input row_kind_e kind, input logic [14:0] v,
                                  input cfg_set_t s, input seg_rec_t w);
    row_t r;
    r.kind = kind;
    r.value = v;
    r.setting = s;
    r.want = w;
    return r;
  endfunction

  task automatic add_item(input logic [14:0] v);
    directed_rows.push_back(mk_row(ROW_ITEM, v, SetReset, '0));
  endtask

  // directed table: extremes, every digit, zero, wrap, ignored indexes
  task automatic build_directed();
    seg_rec_t one_reset;
    one_reset = '{x: 8'd55, y: 8'd22, len: 8'd20, vert: 1'b1, last: 1'b1};
    directed_rows.push_back(mk_row(ROW_TYPED, 15'd1, SetReset, one_reset));
    add_item(15'd0);
    add_item(15'd32767);
    add_item(15'd12345);
    add_item(15'd6789);
    add_item(15'd10000);
    add_item(15'd9);
    add_item(15'd7);
    directed_rows.push_back(mk_row(ROW_SETUP_STRAY, 15'd0, SetReset, '0));
    directed_rows.push_back(mk_row(ROW_TYPED, 15'd1, SetReset, one_reset));
    directed_rows.push_back(mk_row(ROW_SETUP, 15'd0, SetZeros, '0));
    directed_rows.push_back(mk_row(ROW_TYPED, 15'd1, SetZeros,
                                   '{x: 8'd0, y: 8'd0, len: 8'd0, vert: 1'b1, last: 1'b1}));
    add_item(15'd28888);
    add_item(15'd0);
    directed_rows.push_back(mk_row(ROW_SETUP, 15'd0, SetOnes, '0));
    directed_rows.push_back(mk_row(ROW_TYPED, 15'd1, SetOnes,
                                   '{x: 8'd253, y: 8'd255, len: 8'd255, vert: 1'b1,
                                     last: 1'b1}));
    add_item(15'd32767);
    add_item(15'd10);
    directed_rows.push_back(mk_row(ROW_SETUP, 15'd0, SetOdd, '0));
    add_item(15'd25252);
    add_item(15'd4);
    add_item(15'd30303);
    directed_rows.push_back(mk_row(ROW_SETUP, 15'd0, SetReset, '0));
    add_item(15'd10090);
  endtask

  function automatic logic [7:0] roll_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [14:0] draw_value();
    int unsigned pw;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 15'($urandom_range(0, 32767));
      4:          return 15'($urandom_range(0, 9));
      5:          return 15'($urandom_range(10, 999));
      6:          return ($urandom_range(0, 1) != 0) ? 15'd32767 : 15'd0;
      7: begin
        // one digit followed by zeros
        pw = 1;
        repeat ($urandom_range(0, 3)) pw = pw * 10;
        return 15'($urandom_range(1, 9) * pw);
      end
      default:    return 15'($urandom_range(10000, 32767));
    endcase
  endfunction

  // stimulus
  initial begin : stimulus
    row_t     row;
    cfg_set_t s;
    bit       final_phase;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    value <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_ORIGIN_X;
    cfg_data <= '0;
    load_glyphs();
    // register copies start at the documented reset values
    cfg_ox = 8'd30;
    cfg_oy = 8'd22;
    cfg_pitch = 8'd15;
    cfg_width = 8'd10;
    cfg_height = 8'd20;
    build_directed();
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_SETUP:       load_setting(row.setting, 1'b0);
        ROW_SETUP_STRAY: load_setting(row.setting, 1'b1);
        ROW_TYPED: begin
          typed_want = row.want;
          typed_armed = 1'b1;
          offer_value(row.value);
          source_gap();
        end
        default: begin
          offer_value(row.value);
          source_gap();
        end
      endcase
    end

    // random phases, each under a fresh setting
    for (int phase = 0; phase < RandPhases; phase++) begin
      s.ox = roll_byte();
      s.oy = roll_byte();
      s.pitch = roll_byte();
      s.width = roll_byte();
      s.height = roll_byte();
      load_setting(s, $urandom_range(0, 3) == 0);
      final_phase = (phase == RandPhases - 1);
      src_idle_en = !final_phase && ($urandom_range(0, 3) != 0);
      sink_idle_en = !final_phase && ($urandom_range(0, 3) != 0);
      if (phase == 2) begin
        // receiver holds off while the sender keeps offering
        long_stall_req = 1'b1;
        src_idle_en = 1'b0;
      end
      repeat (PhaseItems) begin
        offer_value(draw_value());
        source_gap();
      end
    end

    wait_drained();
    repeat (TailCycles) @(negedge clk);
    if (seg_expect.size() != 0)
      flag_mismatch($sformatf("%0d segments never arrived", seg_expect.size()));
    $display("covered %0d numbers and %0d segments under %0d settings, %0d register writes",
             numbers_taken, segs_seen, settings_loaded, cfg_writes);
    $display("with zero, full scale, wrapped coordinates and ignored register indexes");
    if (err_count == 0) begin
      $display("tb_decimal_segment_digit_renderer_core: done, clean");
    end else begin
      $display("tb_decimal_segment_digit_renderer_core: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/dsdr_pkg.sv
rtl/core/decimal_segment_digit_renderer_core.sv
tb/sv/tb_decimal_segment_digit_renderer_core.sv
